### hw/rtl/rcc_pkg.sv
// Shared types and constants for the RGB 3x3 convolution block.
`timescale 1ns / 1ps

package rcc_pkg;

    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int TAP_W      = 16;
    localparam int NUM_TAPS   = 9;
    localparam int KROW_W     = 3 * TAP_W;
    localparam int PROD_W     = 24;
    localparam int ROW_W      = 26;
    localparam int SUM_W      = 28;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int COUNT_W    = 24;
    localparam int LANE_LAT   = 3;
    localparam int OUT_DEPTH  = 8;

    localparam logic [PIX_W-1:0]   PIX_MAX   = 8'd255;
    localparam logic [IMG_H_W-1:0] ROW_LIMIT = 13'h1FFF;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = KROW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd4;

    localparam logic [KROW_W-1:0]  KERNEL_MID_RST   = 48'h0000_0100_0000;
    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd768;

    typedef logic [RGB_W-1:0] t_pix;
    // window[row][col], row 0 is the row above, col 0 the left column
    typedef logic [2:0][2:0][RGB_W-1:0] t_win;
    typedef logic [NUM_TAPS-1:0][PIX_W-1:0] t_chan_taps;
    typedef logic [NUM_TAPS-1:0][TAP_W-1:0] t_coefs;

    typedef struct packed {
        logic produce;
        logic frame_end;
        logic row_top;
        logic row_bot;
        logic col_left;
        logic col_right;
    } t_ctrl;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_end;
    } t_res;

endpackage

### hw/rtl/rcc_scan.sv
// Raster position tracking, border masks, frame size and frame-end detection.
`timescale 1ns / 1ps

module rcc_scan #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_flush,
    input  logic [rcc_pkg::PIX_W-1:0]   i_red,
    input  logic [rcc_pkg::PIX_W-1:0]   i_green,
    input  logic [rcc_pkg::PIX_W-1:0]   i_blue,
    input  logic                        i_width_we,
    input  logic                        i_height_we,
    input  logic [rcc_pkg::IMG_H_W-1:0] i_cfg_data,
    output logic                        o_act,
    output logic [$clog2(MAX_WIDTH)-1:0] o_addr,
    output rcc_pkg::t_pix               o_pix,
    output rcc_pkg::t_ctrl              o_ctrl
);
    import rcc_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WCAP = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
    localparam logic [IMG_W_W-1:0] W_CAP = IMG_W_W'(WCAP);

    function automatic logic [IMG_W_W-1:0] eff_width(input logic [IMG_W_W-1:0] v);
        logic [IMG_W_W-1:0] res;
        if (v == '0) begin
            res = IMG_W_W'(1);
        end else if (v > W_CAP) begin
            res = W_CAP;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [IMG_H_W-1:0] eff_height(input logic [IMG_H_W-1:0] v);
        return (v == '0) ? IMG_H_W'(1) : v;
    endfunction

    logic [CW-1:0]      r_col;
    logic [IMG_H_W-1:0] r_row;
    logic [COUNT_W-1:0] r_cnt;
    logic [IMG_W_W-1:0] r_w_eff;
    logic [IMG_H_W-1:0] r_h_eff;
    logic [COUNT_W-1:0] r_total;

    logic [IMG_W_W-1:0] n_w_eff;
    logic [IMG_H_W-1:0] n_h_eff;
    logic [COUNT_W-1:0] n_total;

    logic [11:0]        ox;
    logic [IMG_H_W-1:0] oy;
    logic               produce;
    logic               last;
    logic               ignore;
    logic               wrap;
    logic [COUNT_W:0]   cnt_inc;

    // frame size follows each config write, so it is current for the next beat
    always_comb begin
        n_w_eff = r_w_eff;
        n_h_eff = r_h_eff;
        n_total = r_total;
        if (i_width_we) begin
            n_w_eff = eff_width(i_cfg_data[IMG_W_W-1:0]);
            n_total = COUNT_W'(n_w_eff) * COUNT_W'(r_h_eff);
        end else if (i_height_we) begin
            n_h_eff = eff_height(i_cfg_data);
            n_total = COUNT_W'(r_w_eff) * COUNT_W'(n_h_eff);
        end
    end

    always_comb begin
        if (r_col != '0) begin
            ox      = 12'(r_col) - 12'd1;
            oy      = r_row - IMG_H_W'(1);
            produce = (r_row != '0);
        end else begin
            ox      = 12'(r_w_eff) - 12'd1;
            oy      = r_row - IMG_H_W'(2);
            produce = (r_row >= IMG_H_W'(2));
        end
        cnt_inc = (COUNT_W + 1)'(r_cnt) + (COUNT_W + 1)'(1);
        last    = produce && (cnt_inc >= (COUNT_W + 1)'(r_total));
        ignore  = i_flush && (r_row == '0) && (r_col == '0);
        wrap    = (13'(r_col) + 13'd1) >= 13'(r_w_eff);

        o_act            = i_accept && !ignore;
        o_addr           = r_col;
        o_pix            = i_flush ? '0 : {i_blue, i_green, i_red};
        o_ctrl.produce   = produce;
        o_ctrl.frame_end = last;
        o_ctrl.row_top   = (oy != '0);
        o_ctrl.row_bot   = (14'(oy) + 14'd1) < 14'(r_h_eff);
        o_ctrl.col_left  = (ox != '0);
        o_ctrl.col_right = (13'(ox) + 13'd1) < 13'(r_w_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff <= eff_width(IMAGE_WIDTH_RST);
            r_h_eff <= IMAGE_HEIGHT_RST;
            r_total <= COUNT_W'(eff_width(IMAGE_WIDTH_RST)) * COUNT_W'(IMAGE_HEIGHT_RST);
        end else begin
            r_w_eff <= n_w_eff;
            r_h_eff <= n_h_eff;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cnt <= '0;
        end else if (o_act) begin
            if (last) begin
                // last result of the frame: rewind everything
                r_col <= '0;
                r_row <= '0;
                r_cnt <= '0;
            end else begin
                if (produce) begin
                    r_cnt <= cnt_inc[COUNT_W-1:0];
                end
                if (wrap) begin
                    r_col <= '0;
                    if (r_row != ROW_LIMIT) begin
                        r_row <= r_row + IMG_H_W'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

endmodule

### hw/rtl/rcc_line_buf.sv
// Two-row line memory with same-address forwarding and the 3x3 pixel window.
`timescale 1ns / 1ps

module rcc_line_buf #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_act,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  rcc_pkg::t_pix                i_pix,
    input  rcc_pkg::t_ctrl               i_ctrl,
    output logic                         o_valid,
    output rcc_pkg::t_ctrl               o_ctrl,
    output rcc_pkg::t_win                o_win
);
    import rcc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    // each entry holds {row above, current row} for one column
    logic [2*RGB_W-1:0] r_mem [MAX_WIDTH];
    logic [2*RGB_W-1:0] r_rd_data;
    logic               r_fwd;
    logic [2*RGB_W-1:0] r_fwd_data;

    logic               r_s1_valid;
    logic [AW-1:0]      r_s1_addr;
    t_pix               r_s1_pix;
    t_ctrl              r_s1_ctrl;

    t_win               r_win;
    logic               r_s2_valid;
    t_ctrl              r_s2_ctrl;

    logic [2*RGB_W-1:0] s1_data;
    logic [RGB_W-1:0]   s1_top;
    logic [RGB_W-1:0]   s1_mid;
    logic [2*RGB_W-1:0] wr_data;
    logic               hit;

    always_comb begin
        s1_data = r_fwd ? r_fwd_data : r_rd_data;
        s1_top  = s1_data[2*RGB_W-1:RGB_W];
        s1_mid  = s1_data[RGB_W-1:0];
        wr_data = {s1_mid, r_s1_pix};
        hit     = r_s1_valid && (i_addr == r_s1_addr);
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mem[r_s1_addr] <= wr_data;
        end
        if (i_act) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    // back-to-back beats on one column: take the data being written now
    always_ff @(posedge i_clk) begin
        if (i_act) begin
            r_fwd      <= hit;
            r_fwd_data <= wr_data;
            r_s1_addr  <= i_addr;
            r_s1_pix   <= i_pix;
            r_s1_ctrl  <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= s1_top;
            r_win[1][2] <= s1_mid;
            r_win[2][2] <= r_s1_pix;
        end
        r_s2_ctrl <= r_s1_ctrl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_act;
            r_s2_valid <= r_s1_valid && r_s1_ctrl.produce;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_ctrl  = r_s2_ctrl;
    assign o_win   = r_win;

endmodule

### hw/rtl/rcc_lane.sv
// One color channel: nine tap products, row sums, total, shift and clamp.
`timescale 1ns / 1ps

module rcc_lane #(
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                      i_clk,
    input  rcc_pkg::t_chan_taps       i_pix,
    input  rcc_pkg::t_coefs           i_coef,
    input  logic [rcc_pkg::NUM_TAPS-1:0] i_tap_en,
    output logic [rcc_pkg::PIX_W-1:0] o_value
);
    import rcc_pkg::*;

    localparam int SHW = SUM_W - COEF_FRAC_BITS;

    logic signed [PROD_W-1:0] n_prod [NUM_TAPS];
    logic signed [PROD_W-1:0] r_prod [NUM_TAPS];
    logic signed [ROW_W-1:0]  n_row  [3];
    logic signed [ROW_W-1:0]  r_row  [3];
    logic signed [SUM_W-1:0]  n_sum;
    logic [SHW-1:0]           shifted;
    logic [PIX_W-1:0]         n_value;
    logic [PIX_W-1:0]         r_value;

    always_comb begin
        for (int j = 0; j < NUM_TAPS; j++) begin
            // masked taps lie outside the image: zero padding
            if (i_tap_en[j]) begin
                n_prod[j] = PROD_W'(signed'({1'b0, i_pix[j]})) *
                            PROD_W'(signed'(i_coef[j]));
            end else begin
                n_prod[j] = '0;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_row[r] = ROW_W'(r_prod[3*r]) + ROW_W'(r_prod[3*r+1]) +
                       ROW_W'(r_prod[3*r+2]);
        end
    end

    always_comb begin
        n_sum   = SUM_W'(r_row[0]) + SUM_W'(r_row[1]) + SUM_W'(r_row[2]);
        shifted = n_sum[SUM_W-1:COEF_FRAC_BITS];
        if (n_sum[SUM_W-1]) begin
            n_value = '0;
        end else if (shifted > SHW'(PIX_MAX)) begin
            n_value = PIX_MAX;
        end else begin
            n_value = shifted[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_row   <= n_row;
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### hw/rtl/rcc_merge.sv
// Joins the lane results into output beats and queues them for the consumer.
`timescale 1ns / 1ps

module rcc_merge (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_take,
    input  logic                      i_push,
    input  logic [rcc_pkg::PIX_W-1:0] i_red,
    input  logic [rcc_pkg::PIX_W-1:0] i_green,
    input  logic [rcc_pkg::PIX_W-1:0] i_blue,
    input  logic                      i_frame_end,
    output logic                      o_space,
    output logic                      o_valid,
    input  logic                      i_ready,
    output rcc_pkg::t_res             o_res
);
    import rcc_pkg::*;

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    t_res             r_fifo [OUT_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_used;
    logic             pop;
    t_res             push_res;

    always_comb begin
        pop                = o_valid && i_ready;
        push_res.red       = i_red;
        push_res.green     = i_green;
        push_res.blue      = i_blue;
        push_res.frame_end = i_frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_fifo[r_wr_ptr] <= push_res;
        end
    end

    // r_used counts results in flight plus queued, so the queue never overflows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_used   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(pop);
            r_used  <= r_used + CNT_W'(i_take) - CNT_W'(pop);
        end
    end

    assign o_space = (r_used < CNT_W'(OUT_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_res   = r_fifo[r_rd_ptr];

endmodule

### hw/rtl/rgb_conv3x3_clamp.sv
// Top level of the streaming RGB 3x3 convolution with clamp.
`timescale 1ns / 1ps

// Takes one pixel per clock in raster order, while o_ready is high, and
// returns each pixel filtered by a signed Q8.8 3x3 kernel (zero padding at
// the borders), each channel shifted right by COEF_FRAC_BITS and clamped to
// 0..255. A result follows the pixel image_width + 1 beats later; after the
// last pixel of a frame send image_width + 1 beats with flush set to drain it.
// The last result of a frame has frame_end set. Sustained rate is one beat per
// clock while the output queue has room, set by the line memory doing one read
// and one write per pixel. An eight-entry output queue lets input continue
// while results wait. The line memory needs no clearing after reset. Write
// configuration only while no results are outstanding.
module rgb_conv3x3_clamp #(
    parameter int MAX_WIDTH      = 1024,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [rcc_pkg::PIX_W-1:0]      i_red_in,
    input  logic [rcc_pkg::PIX_W-1:0]      i_green_in,
    input  logic [rcc_pkg::PIX_W-1:0]      i_blue_in,
    input  logic                           i_flush,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [rcc_pkg::PIX_W-1:0]      o_red_out,
    output logic [rcc_pkg::PIX_W-1:0]      o_green_out,
    output logic [rcc_pkg::PIX_W-1:0]      o_blue_out,
    output logic                           o_frame_end
);
    import rcc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [2:0][KROW_W-1:0] r_kern;
    logic                   width_we;
    logic                   height_we;

    logic                   accept;
    logic                   act;
    logic [AW-1:0]          addr;
    t_pix                   pix;
    t_ctrl                  scan_ctrl;

    logic                   win_valid;
    t_ctrl                  win_ctrl;
    t_win                   win;

    t_coefs                 coefs;
    logic [NUM_TAPS-1:0]    tap_en;
    t_chan_taps             chan_pix [3];
    logic [PIX_W-1:0]       lane_out [3];

    logic [LANE_LAT-1:0]    r_sb_valid;
    logic [LANE_LAT-1:0]    r_sb_end;
    logic                   space;
    t_res                   res;

    always_comb begin
        width_we  = 1'b0;
        height_we = 1'b0;
        unique case (i_cfg_idx)
            CFG_IMAGE_WIDTH:  width_we  = i_cfg_we;
            CFG_IMAGE_HEIGHT: height_we = i_cfg_we;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kern[0] <= '0;
            r_kern[1] <= KERNEL_MID_RST;
            r_kern[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KERNEL_TOP:    r_kern[0] <= i_cfg_data;
                CFG_KERNEL_MID:    r_kern[1] <= i_cfg_data;
                CFG_KERNEL_BOTTOM: r_kern[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready = space;
    assign accept  = i_valid && space;

    rcc_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_flush     (i_flush),
        .i_red       (i_red_in),
        .i_green     (i_green_in),
        .i_blue      (i_blue_in),
        .i_width_we  (width_we),
        .i_height_we (height_we),
        .i_cfg_data  (i_cfg_data[IMG_H_W-1:0]),
        .o_act       (act),
        .o_addr      (addr),
        .o_pix       (pix),
        .o_ctrl      (scan_ctrl)
    );

    rcc_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_act   (act),
        .i_addr  (addr),
        .i_pix   (pix),
        .i_ctrl  (scan_ctrl),
        .o_valid (win_valid),
        .o_ctrl  (win_ctrl),
        .o_win   (win)
    );

    // spread kernel taps, border masks and window pixels over the lanes
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                coefs[3*r+k]  = r_kern[r][TAP_W*k +: TAP_W];
                tap_en[3*r+k] = ((r == 0) ? win_ctrl.row_top  :
                                 (r == 2) ? win_ctrl.row_bot  : 1'b1) &
                                ((k == 0) ? win_ctrl.col_left :
                                 (k == 2) ? win_ctrl.col_right : 1'b1);
                for (int ch = 0; ch < 3; ch++) begin
                    chan_pix[ch][3*r+k] = win[r][k][PIX_W*ch +: PIX_W];
                end
            end
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        rcc_lane #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_pix    (chan_pix[ch]),
            .i_coef   (coefs),
            .i_tap_en (tap_en),
            .o_value  (lane_out[ch])
        );
    end

    // carry valid and frame end alongside the lane pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb_valid <= '0;
        end else begin
            r_sb_valid <= {r_sb_valid[LANE_LAT-2:0], win_valid};
        end
        r_sb_end <= {r_sb_end[LANE_LAT-2:0], win_ctrl.frame_end};
    end

    rcc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (act && scan_ctrl.produce),
        .i_push      (r_sb_valid[LANE_LAT-1]),
        .i_red       (lane_out[0]),
        .i_green     (lane_out[1]),
        .i_blue      (lane_out[2]),
        .i_frame_end (r_sb_end[LANE_LAT-1]),
        .o_space     (space),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (res)
    );

    assign o_red_out   = res.red;
    assign o_green_out = res.green;
    assign o_blue_out  = res.blue;
    assign o_frame_end = res.frame_end;

endmodule

### bench/tb_top.sv
// Self-checking testbench for the streaming RGB 3x3 convolution with clamp.
`timescale 1ns / 1ps

module tb_top;
    import rcc_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int COEF_FRAC    = 8;
    localparam int RANDOM_BEATS = 1550;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 4_000_000;

    // Bit-true model of the filter; holds the expected output pixels in order.
    class conv_scoreboard;
        logic [KROW_W-1:0]  krow [3];
        logic [IMG_W_W-1:0] width_reg;
        logic [IMG_H_W-1:0] height_reg;
        t_pix               line_mem [2*MAX_W];
        t_pix               win [3][3];
        int unsigned        col, row, out_cnt;
        t_res               filtered_q [$];
        int                 errors;

        function new();
            krow[0] = '0;
            krow[1] = KERNEL_MID_RST;
            krow[2] = '0;
            width_reg = IMAGE_WIDTH_RST;
            height_reg = IMAGE_HEIGHT_RST;
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (win[i, j]) win[i][j] = '0;
            col = 0;
            row = 0;
            out_cnt = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_KERNEL_TOP:    krow[0] = data;
                CFG_KERNEL_MID:    krow[1] = data;
                CFG_KERNEL_BOTTOM: krow[2] = data;
                CFG_IMAGE_WIDTH:   width_reg = data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT:  height_reg = data[IMG_H_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_W) return MAX_W;
            return 32'(width_reg);
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : 32'(height_reg);
        endfunction

        function int unsigned frame_size();
            return eff_width() * eff_height();
        endfunction

        function bit mid_frame();
            return col != 0 || row != 0;
        endfunction

        function int pending();
            return filtered_q.size();
        endfunction

        function logic [PIX_W-1:0] filter_channel(int sh, bit [2:0] rm, bit [2:0] km);
            longint                  acc;
            logic signed [TAP_W-1:0] tap;
            acc = 0;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    if (rm[r] && km[k]) begin
                        tap = krow[r][TAP_W*k +: TAP_W];
                        acc += longint'(win[r][k][sh +: PIX_W]) * longint'(tap);
                    end
                end
            end
            if (acc < 0) return '0;
            acc = acc >>> COEF_FRAC;
            return (acc > PIX_MAX) ? PIX_MAX : acc[PIX_W-1:0];
        endfunction

        // Returns 0 when the beat is an idle flush that the block drops.
        function bit note_input(bit fl, t_pix px);
            int unsigned w, h, total, c, ox, oy;
            t_pix        top, mid, cur;
            bit          ok;
            bit [2:0]    rm, km;
            t_res        res;
            w = eff_width();
            h = eff_height();
            total = w * h;
            if (fl && row == 0 && col == 0) return 0;
            cur = fl ? '0 : px;
            c = (col < MAX_W) ? col : MAX_W - 1;
            top = line_mem[MAX_W + c];
            mid = line_mem[c];
            line_mem[MAX_W + c] = mid;
            line_mem[c] = cur;
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = cur;
            if (col > 0) begin
                ox = col - 1;
                oy = row - 1;
                ok = row >= 1;
            end else begin
                ox = w - 1;
                oy = row - 2;
                ok = row >= 2;
            end
            if (ok) begin
                // bit 0 is the row above / left column
                rm = {oy + 1 < h, 1'b1, oy > 0};
                km = {ox + 1 < w, 1'b1, ox > 0};
                res.red = filter_channel(0, rm, km);
                res.green = filter_channel(PIX_W, rm, km);
                res.blue = filter_channel(2*PIX_W, rm, km);
                out_cnt++;
                res.frame_end = out_cnt >= total;
                filtered_q.push_back(res);
                if (out_cnt >= total) begin
                    col = 0;
                    row = 0;
                    out_cnt = 0;
                    return 1;
                end
            end
            if (col + 1 >= w) begin
                col = 0;
                if (row < ROW_LIMIT) row++;
            end else begin
                col++;
            end
            return 1;
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (filtered_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: r=%0d g=%0d b=%0d end=%0b",
                             got.red, got.green, got.blue, got.frame_end);
                return;
            end
            want = filtered_q.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.frame_end !== want.frame_end) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected r=%0d g=%0d b=%0d end=%0b",
                             want.red, want.green, want.blue, want.frame_end);
                    $display("          got      r=%0d g=%0d b=%0d end=%0b",
                             got.red, got.green, got.blue, got.frame_end);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [PIX_W-1:0]      i_red_in = '0;
    logic [PIX_W-1:0]      i_green_in = '0;
    logic [PIX_W-1:0]      i_blue_in = '0;
    logic                  i_flush = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [PIX_W-1:0]      o_red_out;
    logic [PIX_W-1:0]      o_green_out;
    logic [PIX_W-1:0]      o_blue_out;
    logic                  o_frame_end;

    conv_scoreboard sb = new();
    bit             hold_req = 1'b0;
    bit             src_quiet = 1'b0;
    bit             sink_quiet = 1'b0;
    int             beats_used = 0;
    int             cycles = 0;

    rgb_conv3x3_clamp #(
        .MAX_WIDTH      (MAX_W),
        .COEF_FRAC_BITS (COEF_FRAC)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_flush     (i_flush),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_frame_end (o_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [PIX_W-1:0] rand_chan();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return PIX_MAX;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pix rand_pixel();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    function automatic logic [KROW_W-1:0] rand_kernel_row();
        logic [KROW_W-1:0] bits;
        logic [TAP_W-1:0]  tap;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 9))
                0: tap = TAP_W'($urandom);
                1: tap = '0;
                // mostly taps within about +-1.4
                default: tap = TAP_W'($urandom_range(0, 700) - 350);
            endcase
            bits[TAP_W*k +: TAP_W] = tap;
        end
        return bits;
    endfunction

    // Put random junk above a narrow register's field.
    function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned v, int bits);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'({$urandom, $urandom});
        if ($urandom_range(0, 1) == 0) junk = '0;
        return (junk << bits) | CFG_DATA_W'(v);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic write_kernel(logic [KROW_W-1:0] top, logic [KROW_W-1:0] mid,
                                logic [KROW_W-1:0] bot);
        write_reg(CFG_KERNEL_TOP, top);
        write_reg(CFG_KERNEL_MID, mid);
        write_reg(CFG_KERNEL_BOTTOM, bot);
    endtask

    task automatic write_size(int w, int h);
        write_reg(CFG_IMAGE_WIDTH, with_junk(w, IMG_W_W));
        write_reg(CFG_IMAGE_HEIGHT, with_junk(h, IMG_H_W));
    endtask

    task automatic send_beat(bit fl, t_pix px);
        int gap;
        gap = src_quiet ? 0 : pick_gap();
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_flush <= fl;
        i_red_in <= px[PIX_W-1:0];
        i_green_in <= px[2*PIX_W-1:PIX_W];
        i_blue_in <= px[3*PIX_W-1:2*PIX_W];
        do @(posedge i_clk); while (!o_ready);
        if (sb.note_input(fl, px)) beats_used++;
    endtask

    task automatic send_pixels(int n, int flush_pct);
        repeat (n) send_beat($urandom_range(0, 99) < flush_pct, rand_pixel());
    endtask

    // Flush until the frame closes; now and then slip in a pixel below the image.
    task automatic drain_frame(int pixel_pct);
        while (sb.mid_frame())
            send_beat(!($urandom_range(0, 99) < pixel_pct), rand_pixel());
    endtask

    // Drop valid and wait for every outstanding result plus the pipeline depth.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic setup_phase();
        int roll, w, h;
        write_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        roll = $urandom_range(0, 99);
        w = (roll < 5) ? 0 : (roll < 80) ? $urandom_range(1, 8) : $urandom_range(9, 32);
        roll = $urandom_range(0, 99);
        h = (roll < 5) ? 0 : (roll < 85) ? $urandom_range(1, 6) : $urandom_range(7, 12);
        write_size(w, h);
    endtask

    initial begin : sink
        int   stall;
        t_res seen;
        int   hold_left;
        stall = 0;
        hold_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                seen.red = o_red_out;
                seen.green = o_green_out;
                seen.blue = o_blue_out;
                seen.frame_end = o_frame_end;
                sb.check_result(seen);
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else begin
                stall = sink_quiet ? 0 : pick_gap();
                i_ready <= (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("rgb_conv3x3_clamp test failed");
        $finish;
    end

    initial begin : stimulus
        int base, n, guard;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Flushes with nothing outstanding are dropped.
        send_beat(1'b1, rand_pixel());
        send_beat(1'b1, {8'd255, 8'd255, 8'd255});
        settle();

        // Zero width and height act as one; max taps clamp high.
        write_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        write_size(0, 0);
        send_beat(1'b0, {8'd128, 8'd0, 8'd255});
        drain_frame(0);
        settle();

        // Mixed signs, most negative tap, field extremes, early flush, extra pixel.
        write_kernel({16'h0080, 16'h8000, 16'hFF00}, {16'hFFFF, 16'h0400, 16'h0100},
                     {16'h7FFF, 16'hFF80, 16'h0000});
        write_size(3, 3);
        send_beat(1'b0, {8'd0, 8'd0, 8'd0});
        send_beat(1'b0, {8'd255, 8'd255, 8'd255});
        send_beat(1'b0, {8'd0, 8'd0, 8'd255});
        send_beat(1'b1, {8'd255, 8'd255, 8'd255});
        send_beat(1'b0, {8'd0, 8'd255, 8'd0});
        send_beat(1'b0, {8'd255, 8'd0, 8'd0});
        send_beat(1'b0, {8'd254, 8'd128, 8'd1});
        send_beat(1'b0, {8'd255, 8'd255, 8'd255});
        send_beat(1'b0, {8'd0, 8'd0, 8'd0});
        send_beat(1'b0, {8'd50, 8'd100, 8'd200});
        drain_frame(0);
        settle();

        // Shrink the frame while inside it: the column wraps, the frame ends early.
        write_size(4, 4);
        send_pixels(7, 0);
        settle();
        write_size(3, 2);
        drain_frame(0);
        settle();

        // Back-pressure: sink holds off while the source streams without gaps.
        write_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        write_size(12, 8);
        src_quiet = 1'b1;
        hold_req = 1'b1;
        send_pixels(sb.frame_size(), 3);
        drain_frame(10);
        src_quiet = 1'b0;
        settle();

        base = beats_used;
        while (beats_used - base < RANDOM_BEATS) begin
            settle();
            src_quiet = $urandom_range(0, 5) == 0;
            sink_quiet = $urandom_range(0, 5) == 0;
            setup_phase();
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 9) == 0)
                    send_pixels($urandom_range(1, 2), 100);
                n = sb.frame_size();
                if (n > 1 && $urandom_range(0, 4) == 0) begin
                    send_pixels($urandom_range(1, n - 1), 5);
                    settle();
                    if ($urandom_range(0, 1) == 0)
                        write_reg(CFG_IMAGE_WIDTH, with_junk($urandom_range(1, 8), IMG_W_W));
                    if ($urandom_range(0, 1) == 0)
                        write_reg(CFG_IMAGE_HEIGHT, with_junk($urandom_range(1, 6), IMG_H_W));
                    if ($urandom_range(0, 3) == 0)
                        write_reg(CFG_KERNEL_MID, rand_kernel_row());
                end else begin
                    send_pixels(n, 5);
                end
                drain_frame(15);
            end
        end

        i_valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("rgb_conv3x3_clamp test passed");
        else
            $display("rgb_conv3x3_clamp test failed");
        $finish;
    end

endmodule
